// File: rtl/hcbp_pkg.sv
// Shared types and constants of the Huffman code bit packer.
// No dependencies; compiled first.
package hcbp_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int SYM_W        = 8;
    localparam int LEN_W        = 6;
    localparam int CODE_W       = 32;
    localparam int BYTE_W       = 8;
    localparam int PEND_W       = 7;
    localparam int ACC_W        = PEND_W + CODE_W;
    localparam int CNT_W        = 6;
    localparam int ENTRY_W      = LEN_W + CODE_W;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [BYTE_W-1:0] FLUSH_EMPTY_BYTE = 8'd8;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic combine;
        logic emit_data;
        logic emit_pad;
        logic emit_count;
    } hcbp_cmd_t;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] in_op;
        logic       cnt_zero;
        logic       cnt_ge8;
        logic       cnt_ge16;
        logic       out_free;
    } hcbp_status_t;

endpackage

// File: rtl/hcbp_if.sv
// Request and result channel interfaces of the Huffman code bit packer.
// Depends on hcbp_pkg.
interface hcbp_item_if
    import hcbp_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  code_length;
    logic [CODE_W-1:0] code_bits;

    modport source (output valid, opcode, symbol, code_length, code_bits, input ready);
    modport sink   (input valid, opcode, symbol, code_length, code_bits, output ready);
endinterface

interface hcbp_result_if
    import hcbp_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, out_byte, last, input ready);
    modport sink   (input valid, out_byte, last, output ready);
endinterface

// File: rtl/hcbp_ram.sv
// Single-port RAM with registered read, no reset on the array.
// No dependencies.
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/hcbp_ctrl.sv
// Controller state machine: sequences lookup, byte emission and flush.
// Depends on hcbp_pkg.
module hcbp_ctrl
    import hcbp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  hcbp_status_t status,
    output hcbp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_COMBINE = 5'b00010,
        ST_EMIT    = 5'b00100,
        ST_PAD     = 5'b01000,
        ST_COUNT   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.accept   = status.in_valid;
                if (status.in_valid)
                begin
                    case (status.in_op)
                        OP_ENCODE: state_next = ST_COMBINE;
                        OP_FINISH: state_next = status.cnt_zero ? ST_COUNT : ST_PAD;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_COMBINE:
            begin
                cmd.combine = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!status.cnt_ge8)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.emit_data = 1'b1;
                    if (!status.cnt_ge16)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PAD:
            begin
                if (status.out_free)
                begin
                    cmd.emit_pad = 1'b1;
                    state_next   = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_count = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/hcbp_datapath.sv
// Datapath: code table RAM, bit accumulator and output register.
// Depends on hcbp_pkg, hcbp_if and hcbp_ram.
module hcbp_datapath
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    hcbp_item_if.sink      item,
    hcbp_result_if.source  result,
    input  hcbp_cmd_t      cmd,
    output hcbp_status_t   status
);

    localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic [BYTE_W-1:0]  out_byte_next;
    logic               last_reg;
    logic               last_next;

    logic [LEN_W-1:0]   len_clamped;
    logic [ENTRY_W-1:0] rd_entry;
    logic [LEN_W-1:0]   rd_len;
    logic [CODE_W-1:0]  rd_code;
    logic [CODE_W-1:0]  code_mask;
    logic [PEND_W-1:0]  pend_mask;
    logic [ACC_W-1:0]   acc_comb;
    logic [BYTE_W-1:0]  data_byte;
    logic [BYTE_W-1:0]  pad_byte;
    logic [BYTE_W-1:0]  count_byte;
    logic               out_free;
    logic               cnt_zero;
    logic               cnt_ge16;

    assign len_clamped = (item.code_length > LEN_W'(LEN_LIMIT)) ?
                         LEN_W'(LEN_LIMIT) : item.code_length;

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (cmd.accept && (item.opcode == OP_LOAD)),
        .addr  (item.symbol),
        .wdata ({len_clamped, item.code_bits}),
        .rdata (rd_entry)
    );

    assign rd_len  = rd_entry[ENTRY_W-1:CODE_W];
    assign rd_code = rd_entry[CODE_W-1:0];

    assign code_mask = CODE_W'((33'd1 << rd_len) - 33'd1);
    assign pend_mask = PEND_W'((8'd1 << cnt_reg[2:0]) - 8'd1);
    assign acc_comb  = (ACC_W'(acc_reg[PEND_W-1:0] & pend_mask) << rd_len)
                     | ACC_W'(rd_code & code_mask);

    assign cnt_zero   = (cnt_reg == '0);
    assign cnt_ge16   = (cnt_reg >= CNT_W'(16));
    assign data_byte  = BYTE_W'(acc_reg >> (cnt_reg - CNT_W'(BYTE_W)));
    assign pad_byte   = acc_reg[BYTE_W-1:0] << (4'(BYTE_W) - {1'b0, cnt_reg[2:0]});
    assign count_byte = cnt_zero ? FLUSH_EMPTY_BYTE : BYTE_W'(cnt_reg);
    assign out_free   = !out_valid_reg || result.ready;

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (cmd.combine)
        begin
            acc_next = acc_comb;
            cnt_next = cnt_reg + rd_len;
        end
        else if (cmd.emit_data)
        begin
            cnt_next = cnt_reg - CNT_W'(BYTE_W);
        end
        else if (cmd.emit_count)
        begin
            acc_next = '0;
            cnt_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        if (cmd.emit_data)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = data_byte;
            last_next      = !cnt_ge16;
        end
        else if (cmd.emit_pad)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = pad_byte;
            last_next      = 1'b0;
        end
        else if (cmd.emit_count)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = count_byte;
            last_next      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    assign item.ready      = cmd.in_ready;
    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;
    assign result.last     = last_reg;

    assign status.in_valid = item.valid;
    assign status.in_op    = item.opcode;
    assign status.cnt_zero = cnt_zero;
    assign status.cnt_ge8  = (cnt_reg >= CNT_W'(BYTE_W));
    assign status.cnt_ge16 = cnt_ge16;
    assign status.out_free = out_free;

endmodule

// File: rtl/huffman_code_bit_packer.sv
// Channel  | Modport | Payload                                   | Handshake
// item     | sink    | opcode, symbol, code_length, code_bits    | valid/ready
// result   | source  | out_byte, last                            | valid/ready
//
// Load and unused requests end at acceptance; an encode request passes the registered
// code table read and the combine step, then one byte per cycle from the accumulator
// while the result is free. A finish sends a pad byte if bits remain, then a count byte.
// Reset clears the accumulator and handshake state; the code table is not cleared.
// A stalled result holds the controller; the next request is taken while the
// last result of the previous one still waits in the output register.
module huffman_code_bit_packer
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    hcbp_item_if.sink     item,
    hcbp_result_if.source result
);

    hcbp_cmd_t    cmd;
    hcbp_status_t status;

    hcbp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    hcbp_datapath #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cmd    (cmd),
        .status (status)
    );

endmodule

// File: rtl/hcbp_checker.sv
// Port-level assertions for the Huffman code bit packer, bound to the top level.
// Depends on hcbp_pkg and huffman_code_bit_packer.
module hcbp_checker
    import hcbp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input logic [1:0]        item_opcode,
    input logic              result_valid,
    input logic              result_ready,
    input logic [BYTE_W-1:0] result_out_byte,
    input logic              result_last
);

    logic item_fire;

    assign item_fire = item_valid && item_ready;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_out_byte) && $stable(result_last))
        else $error("stalled result changed");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && (item_opcode == OP_LOAD) && !result_valid |=> !result_valid)
        else $error("load request produced a result");

    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && (item_opcode == OP_FINISH) |=> !item_ready)
        else $error("request taken during flush");

    a_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_last |-> !item_ready)
        else $error("request taken before burst end");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .item_opcode     (item.opcode),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_out_byte (result.out_byte),
    .result_last     (result.last)
);
